### sv/odd_even_transposition_sorter_macros.svh
// assertion macros for the odd-even transposition sorter
// used by files that carry concurrent assertions; clock i_clk, reset i_rst_n
`ifndef ODD_EVEN_TRANSPOSITION_SORTER_MACROS_SVH
`define ODD_EVEN_TRANSPOSITION_SORTER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define OETS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OETS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OETS_ASSERT_IMPL(label, ante, cons)
`define OETS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### sv/oets_pkg.sv
// shared types and constants for the odd-even transposition sorter
// no dependencies
`default_nettype none

package oets_pkg;

    localparam int VAL_W = 32;

    typedef logic signed [VAL_W-1:0] t_value;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic sort;
        logic odd;
        logic emit;
    } t_cell_ctl;

endpackage

`default_nettype wire

### sv/odd_even_transposition_sorter.sv
// odd-even transposition sorter: top level, chain of sorting cells plus sequencer
// depends on oets_pkg, oets_cell, oets_ctrl
//
//   channel  signals                                      direction
//   input    i_valid, o_stall, i_value, i_last            in
//   output   o_valid, i_stall, o_value_res, o_last_res,   out
//            o_overflow
//
// a set of items loads at one item per cycle, then passes through the sort phases
// (one compare-swap phase across the whole cell chain per cycle), then is emitted item by item
// input stall is high during sort and emit; emit advances only on unstalled cycles
// synchronous active-low reset clears the sequencer; cell contents need no reset
`default_nettype none

module odd_even_transposition_sorter import oets_pkg::*; #(
    parameter int MAX_ITEMS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_value,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_value_res,
    output logic             o_last_res,
    output logic             o_overflow
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    t_cell_ctl        ctl;
    logic [CNT_W-1:0] count;
    t_value           vals [MAX_ITEMS];
    logic             gts  [MAX_ITEMS];

    oets_ctrl #(
        .MAX_ITEMS (MAX_ITEMS),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_last     (i_last),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_last_res (o_last_res),
        .o_overflow (o_overflow),
        .o_ctl      (ctl),
        .o_count    (count)
    );

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        t_value left;
        t_value right;
        logic   left_gt;

        if (g == 0) begin : g_head
            assign left    = t_value'(i_value);
            assign left_gt = 1'b0;
        end else begin : g_body
            assign left    = vals[g-1];
            assign left_gt = gts[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_tail
            assign right = '0;
        end else begin : g_inner
            assign right = vals[g+1];
        end

        oets_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_count   (count),
            .i_left    (left),
            .i_right   (right),
            .i_left_gt (left_gt),
            .o_value   (vals[g]),
            .o_gt      (gts[g])
        );
    end

    assign o_value_res = 32'(vals[0]);

endmodule

`default_nettype wire

### sv/oets_cell.sv
// one cell of the sorting chain: holds one value, shifts and compare-swaps
// depends on oets_pkg
`default_nettype none

module oets_cell import oets_pkg::*; #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  wire logic             i_clk,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [CNT_W-1:0] i_count,
    input  wire t_value           i_left,
    input  wire t_value           i_right,
    input  wire logic             i_left_gt,
    output t_value                o_value,
    output logic                  o_gt
);

    localparam logic [CNT_W-1:0] IDX_SELF = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(INDEX + 1);
    localparam bit               IDX_ODD  = (INDEX % 2) == 1;
    localparam bit               HAS_LEFT = INDEX > 0;

    t_value r_val;
    t_value n_val;
    logic   lower;
    logic   upper;

    assign o_gt    = r_val > i_right;
    assign o_value = r_val;

    always_comb begin
        lower = i_ctl.sort && (i_ctl.odd == IDX_ODD) && (IDX_NEXT < i_count);
        upper = i_ctl.sort && (i_ctl.odd != IDX_ODD) && HAS_LEFT && (IDX_SELF < i_count);
        if (i_ctl.load) begin
            n_val = i_left;
        end else if (i_ctl.emit) begin
            n_val = i_right;
        end else if (lower && o_gt) begin
            n_val = i_right;
        end else if (upper && i_left_gt) begin
            n_val = i_left;
        end else begin
            n_val = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

`default_nettype wire

### sv/oets_ctrl.sv
// sequencer for the sorter: load, sort phases, emit; count and drop flag
// depends on oets_pkg and odd_even_transposition_sorter_macros.svh
`default_nettype none

`include "odd_even_transposition_sorter_macros.svh"

module oets_ctrl import oets_pkg::*; #(
    parameter int MAX_ITEMS = 16,
    parameter int CNT_W     = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_last,
    output logic                  o_stall,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic                  o_last_res,
    output logic                  o_overflow,
    output t_cell_ctl             o_ctl,
    output logic [CNT_W-1:0]      o_count
);

    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_phase;
    logic [CNT_W-1:0] n_phase;
    logic             r_dropped;
    logic             n_dropped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_phase   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_phase   <= n_phase;
            r_dropped <= n_dropped;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_phase   = r_phase;
        n_dropped = r_dropped;
        o_ctl     = '{load: 1'b0, sort: 1'b0, odd: r_phase[0], emit: 1'b0};
        o_stall   = 1'b1;
        o_valid   = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (r_count < CAP) begin
                        o_ctl.load = 1'b1;
                        n_count    = r_count + ONE;
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_last) begin
                        n_state = ST_SORT;
                        n_phase = '0;
                    end
                end
            end
            ST_SORT: begin
                o_ctl.sort = 1'b1;
                n_phase    = r_phase + ONE;
                if (r_phase == r_count - ONE) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    o_ctl.emit = 1'b1;
                    n_count    = r_count - ONE;
                    if (r_count == ONE) begin
                        n_state   = ST_LOAD;
                        n_dropped = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_last_res = r_count == ONE;
    assign o_overflow = r_dropped;
    assign o_count    = r_count;

    `OETS_ASSERT_IMPL(a_count_range, 1'b1, r_count <= CAP)
    `OETS_ASSERT_IMPL(a_emit_nonempty, r_state == ST_EMIT, r_count != '0)
    `OETS_ASSERT_IMPL(a_phase_range, r_state == ST_SORT, r_phase < r_count)
    `OETS_ASSERT_NEXT(a_set_done, o_valid && !i_stall && o_last_res,
        r_state == ST_LOAD && r_count == '0 && !r_dropped)

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// testbench for odd_even_transposition_sorter: random and directed sets, sorted output checked
// depends on oets_pkg and the sorter rtl; predicts each set by odd-even transposition phases

module testbench;
    import oets_pkg::*;

    localparam int CAPACITY = 16;
    localparam int RANDOM_ITEMS = 195;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        t_value value;
        logic   last;
        logic   overflow;
    } t_sorted_item;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    t_value i_value = '0;
    logic   i_last = 1'b0;
    logic   i_stall = 1'b0;
    logic   o_stall;
    logic   o_valid;
    logic [31:0] o_value_res;
    logic   o_last_res;
    logic   o_overflow;

    // predictor state for the set being collected
    t_value set_vals [CAPACITY];
    int     set_count = 0;
    logic   set_dropped = 1'b0;
    t_sorted_item sorted_q [$];

    bit in_idle = 1'b0;
    bit out_idle = 1'b0;
    int mismatches = 0;

    odd_even_transposition_sorter #(
        .MAX_ITEMS(CAPACITY)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_value    (i_value),
        .i_last     (i_last),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_value_res(o_value_res),
        .o_last_res (o_last_res),
        .o_overflow (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_value random_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom;
        if (r < 85) return $signed($urandom_range(0, 7)) - 4;
        case ($urandom_range(0, 3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // sort the collected set and queue its results
    task automatic close_set();
        t_value tmp;
        t_sorted_item item;
        for (int phase = 0; phase < set_count; phase++) begin
            for (int i = phase % 2; i + 1 < set_count; i += 2) begin
                if (set_vals[i] > set_vals[i + 1]) begin
                    tmp = set_vals[i];
                    set_vals[i] = set_vals[i + 1];
                    set_vals[i + 1] = tmp;
                end
            end
        end
        for (int k = 0; k < set_count; k++) begin
            item.value = set_vals[k];
            item.last = (k == set_count - 1);
            item.overflow = set_dropped;
            sorted_q.push_back(item);
        end
        set_count = 0;
        set_dropped = 1'b0;
    endtask

    task automatic send_item(input t_value item_value, input logic item_last);
        int gap;
        gap = in_idle ? idle_cycles() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_value <= item_value;
        i_last <= item_last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        if (set_count < CAPACITY) begin
            set_vals[set_count] = item_value;
            set_count++;
        end else begin
            set_dropped = 1'b1;
        end
        if (item_last) close_set();
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sorted_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_single_item();
        in_idle = 1'b0;
        out_idle = 1'b0;
        send_item(32'h8000_0000, 1'b1);
        drain();
    endtask

    task automatic test_extremes();
        t_value vals [6];
        vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h1, 32'h8000_0000};
        in_idle = 1'b1;
        out_idle = 1'b1;
        foreach (vals[k]) send_item(vals[k], k == 5);
        drain();
    endtask

    task automatic test_overflow();
        in_idle = 1'b0;
        out_idle = 1'b1;
        // descending fill, then one dropped item and a dropped item closing the set
        for (int k = 0; k < CAPACITY; k++) send_item(1000 - 137 * k, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7fff_ffff, 1'b1);
        drain();
    endtask

    task automatic test_random_sets();
        int sent;
        int size;
        int r;
        logic [1:0] mode;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 3);
            in_idle = mode[0];
            out_idle = mode[1];
            r = $urandom_range(0, 99);
            if (r < 8) size = 1;
            else if (r < 88) size = $urandom_range(2, CAPACITY);
            else size = $urandom_range(CAPACITY + 1, CAPACITY + 4);
            for (int k = 0; k < size; k++) send_item(random_value(), k == size - 1);
            sent += size;
        end
        drain();
    endtask

    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (!out_idle) begin
                i_stall <= 1'b0;
                hold = 0;
            end else if (hold > 0) begin
                hold--;
            end else if ($urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                hold = idle_cycles();
            end else begin
                i_stall <= 1'b0;
                hold = $urandom_range(0, 4);
            end
        end
    end

    always @(posedge i_clk) begin
        t_sorted_item want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0 && i_stall === 1'b0) begin
            if (sorted_q.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: unexpected transaction value %h last %b overflow %b",
                             $realtime, o_value_res, o_last_res, o_overflow);
                mismatches++;
            end else begin
                want = sorted_q.pop_front();
                if (o_valid !== 1'b1 || o_value_res !== want.value
                        || o_last_res !== want.last || o_overflow !== want.overflow) begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: expected value %h last %b overflow %b, got %h %b %b",
                                 $realtime, want.value, want.last, want.overflow,
                                 o_value_res, o_last_res, o_overflow);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_single_item();
        test_extremes();
        test_overflow();
        test_random_sets();
        repeat (2 * CAPACITY + 10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
